// ----- rtl/urxf_pkg.sv -----
// Shared types and constants of the UART receive FIFO session framer.
`timescale 1ns / 1ps

package urxf_pkg;

   // Request action codes, as they appear on the request channel
   typedef enum logic [1:0] {
      ACT_RX    = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_START = 2'd2,
      ACT_FLUSH = 2'd3
   } action_type;

   // Why a session ended (only meaningful on the last result)
   typedef enum logic [1:0] {
      CAUSE_LENGTH  = 2'd0,
      CAUSE_TIMEOUT = 2'd1,
      CAUSE_GAP     = 2'd2
   } cause_type;

   // Sequencer states of the back end
   typedef enum logic [1:0] {
      BE_IDLE  = 2'd0,
      BE_FETCH = 2'd1,
      BE_EMIT  = 2'd2
   } be_state_type;

   // Classified request handed from front end to back end
   typedef struct packed {
      action_type  action;
      logic [7:0]  rx_data;
      logic [15:0] max_length;
      logic [15:0] timeout_ticks;
   } cmd_type;

   // One result as it sits in the result queue
   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  byte_out;
      logic [15:0] received_count;
      logic        last;
      cause_type   end_cause;
   } result_type;

   // Default ring size and configuration reset value
   localparam int         FIFO_DEPTH_DEF = 32;
   localparam logic [7:0] GAP_TICKS_RST  = 8'd2;

   // Small decoupling queues; pointers wrap naturally, so keep this a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Saturation limits of the session tick counters
   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
   localparam logic [7:0]  IDLE_MAX    = 8'hFF;

endpackage

// ----- rtl/uart_rx_fifo_gap_framer.sv -----
// Top level of the UART receive FIFO session framer with idle-gap timeout.
//
// Requests enter through req_push/req_full: an rx byte event, a tick, a
// session start (max_length, timeout_ticks) or a ring flush. Results leave
// through rsp_empty/rsp_pop; the oldest result stays on the rsp_ ports
// while rsp_empty is low. csr_gap_ticks is written with csr_valid/csr_ready
// (always ready) and sets the idle gap that closes a session.
// A two-entry command queue parts the request side from the back end, and a
// two-entry result queue parts the back end from the response side.
// The back end takes one request per cycle while idle with result queue space.
// A delivered byte takes a ring read (FETCH) and an emit (EMIT), so a start
// drains buffered bytes one at a time; rx bytes in a session go through
// FETCH and EMIT to rsp, tick and zero start results straight from IDLE.
// When the consumer stalls, the result queue fills, the back end holds, the
// command queue fills and req_full rises; nothing is dropped.
// Reset empties both queues and the ring, closes the session and sets
// gap_ticks to 2. Ring contents are not cleared and are never read unwritten.
`timescale 1ns / 1ps

module uart_rx_fifo_gap_framer #(
   parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_action,
   input  logic        req_rx_valid,
   input  logic [7:0]  req_rx_data,
   input  logic [15:0] req_max_length,
   input  logic [15:0] req_timeout_ticks,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_byte_out,
   output logic [15:0] rsp_received_count,
   output logic        rsp_last,
   output logic [1:0]  rsp_end_cause,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_gap_ticks
);

   logic [7:0]            gap_ff;
   logic                  cmd_valid;
   logic                  cmd_pop;
   urxf_pkg::cmd_type     cmd;
   logic                  res_push;
   logic                  res_space;
   urxf_pkg::result_type  res;
   urxf_pkg::result_type  head;

   // Configuration register: write it only while the block is idle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= urxf_pkg::GAP_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         gap_ff <= csr_gap_ticks;
      end
   end

   urxf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_action        (req_action),
      .req_rx_valid      (req_rx_valid),
      .req_rx_data       (req_rx_data),
      .req_max_length    (req_max_length),
      .req_timeout_ticks (req_timeout_ticks),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   urxf_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .gap_ticks (gap_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .res_space (res_space),
      .res_push  (res_push),
      .res       (res)
   );

   urxf_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res       (res),
      .res_space (res_space),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (head)
   );

   // Unpack the head result onto the response ports
   assign rsp_byte_valid     = head.byte_valid;
   assign rsp_byte_out       = head.byte_out;
   assign rsp_received_count = head.received_count;
   assign rsp_last           = head.last;
   assign rsp_end_cause      = head.end_cause;

endmodule

// ----- rtl/urxf_front.sv -----
// Front end: accepts requests, drops empty rx events, queues commands for the back end.
`timescale 1ns / 1ps

module urxf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_action,
   input  logic                 req_rx_valid,
   input  logic [7:0]           req_rx_data,
   input  logic [15:0]          req_max_length,
   input  logic [15:0]          req_timeout_ticks,
   output logic                 cmd_valid,
   output urxf_pkg::cmd_type    cmd,
   input  logic                 cmd_pop
);

   urxf_pkg::cmd_type                  queue_ff [urxf_pkg::QUEUE_DEPTH];
   logic [urxf_pkg::QPTR_W-1:0]        wp_ff, wp_in;
   logic [urxf_pkg::QPTR_W-1:0]        rp_ff, rp_in;
   logic [urxf_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                               accept;
   logic                               keep;
   logic                               do_pop;
   urxf_pkg::cmd_type                  entry;

   assign req_full  = (cnt_ff == urxf_pkg::QCNT_W'(urxf_pkg::QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = queue_ff[rp_ff];
   assign do_pop    = cmd_pop && cmd_valid;

   // Classify: an rx event without the data flag carries nothing, drop it here
   assign accept = req_push && !req_full;
   assign keep   = accept &&
                   !((urxf_pkg::action_type'(req_action) == urxf_pkg::ACT_RX) && !req_rx_valid);

   always_comb begin
      entry.action        = urxf_pkg::action_type'(req_action);
      entry.rx_data       = req_rx_data;
      entry.max_length    = req_max_length;
      entry.timeout_ticks = req_timeout_ticks;
   end

   // Advance pointers and occupancy
   always_comb begin
      wp_in  = keep   ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (keep && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!keep && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the command payload
   always_ff @(posedge clock) begin
      if (keep) begin
         queue_ff[wp_ff] <= entry;
      end
   end

endmodule

// ----- rtl/urxf_back.sv -----
// Back end: byte ring, session state and delivery sequencer.
`timescale 1ns / 1ps

module urxf_back #(
   parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              gap_ticks,
   input  logic                    cmd_valid,
   input  urxf_pkg::cmd_type       cmd,
   output logic                    cmd_pop,
   input  logic                    res_space,
   output logic                    res_push,
   output urxf_pkg::result_type    res
);

   localparam int               IDX_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);

   // Ring step with wrap at the last slot
   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   logic [7:0]               mem [FIFO_DEPTH];
   logic [7:0]               rd_data_ff;
   logic                     mem_we;

   urxf_pkg::be_state_type   state_ff, state_in;
   logic [IDX_W-1:0]         wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     active_ff, active_in;
   logic                     drain_ff, drain_in;
   logic [15:0]              count_ff, count_in;
   logic [15:0]              elapsed_ff, elapsed_in;
   logic [7:0]               idle_ff, idle_in;
   logic [15:0]              limit_ff, limit_in;
   logic [15:0]              timeout_ff, timeout_in;

   logic [IDX_W-1:0]         wr_next;
   logic [IDX_W-1:0]         rd_next;
   logic [15:0]              elapsed_inc;
   logic [7:0]               idle_inc;
   logic [7:0]               gap_eff;
   logic [15:0]              count_inc;
   logic                     done;
   logic                     start_zero;
   logic                     take;

   assign wr_next     = idx_inc(wr_idx_ff);
   assign rd_next     = idx_inc(rd_idx_ff);
   assign elapsed_inc = (elapsed_ff == urxf_pkg::ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
   assign idle_inc    = (idle_ff == urxf_pkg::IDLE_MAX) ? idle_ff : idle_ff + 8'd1;
   assign gap_eff     = (gap_ticks == 8'd0) ? 8'd1 : gap_ticks;
   assign count_inc   = count_ff + 16'd1;
   assign done        = (count_inc >= limit_ff);
   assign start_zero  = (cmd.max_length == 16'd0) || (cmd.timeout_ticks == 16'd0);
   assign take        = (state_ff == urxf_pkg::BE_IDLE) && cmd_valid && res_space;

   // Next state of the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         urxf_pkg::BE_IDLE: begin
            if (take) begin
               case (cmd.action)
                  urxf_pkg::ACT_RX: begin
                     if (active_ff) begin
                        state_in = urxf_pkg::BE_FETCH;
                     end
                  end
                  urxf_pkg::ACT_START: begin
                     if (!start_zero && (rd_idx_ff != wr_idx_ff)) begin
                        state_in = urxf_pkg::BE_FETCH;
                     end
                  end
                  default: state_in = urxf_pkg::BE_IDLE;
               endcase
            end
         end
         urxf_pkg::BE_FETCH: state_in = urxf_pkg::BE_EMIT;
         urxf_pkg::BE_EMIT: begin
            if (res_space) begin
               state_in = (drain_ff && !done && (rd_next != wr_idx_ff)) ?
                          urxf_pkg::BE_FETCH : urxf_pkg::BE_IDLE;
            end
         end
         default: state_in = urxf_pkg::BE_IDLE;
      endcase
   end

   // Command execution, session bookkeeping and result generation
   always_comb begin
      cmd_pop    = 1'b0;
      res_push   = 1'b0;
      res        = '0;
      mem_we     = 1'b0;
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      active_in  = active_ff;
      drain_in   = drain_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      idle_in    = idle_ff;
      limit_in   = limit_ff;
      timeout_in = timeout_ff;
      case (state_ff)
         urxf_pkg::BE_IDLE: begin
            if (take) begin
               cmd_pop = 1'b1;
               case (cmd.action)
                  urxf_pkg::ACT_RX: begin
                     // Buffer unless the ring is full; an open session takes the oldest byte
                     if (wr_next != rd_idx_ff) begin
                        mem_we    = 1'b1;
                        wr_idx_in = wr_next;
                     end
                     drain_in = 1'b0;
                  end
                  urxf_pkg::ACT_TICK: begin
                     if (active_ff) begin
                        elapsed_in = elapsed_inc;
                        idle_in    = idle_inc;
                        if (elapsed_inc >= timeout_ff) begin
                           active_in          = 1'b0;
                           res_push           = 1'b1;
                           res.received_count = count_ff;
                           res.last           = 1'b1;
                           res.end_cause      = urxf_pkg::CAUSE_TIMEOUT;
                        end else if ((count_ff != 16'd0) && (idle_inc >= gap_eff)) begin
                           active_in          = 1'b0;
                           res_push           = 1'b1;
                           res.received_count = count_ff;
                           res.last           = 1'b1;
                           res.end_cause      = urxf_pkg::CAUSE_GAP;
                        end
                     end
                  end
                  urxf_pkg::ACT_START: begin
                     // Open a fresh session; a zero limit or timeout closes it at once
                     count_in   = 16'd0;
                     elapsed_in = 16'd0;
                     idle_in    = 8'd0;
                     limit_in   = cmd.max_length;
                     timeout_in = cmd.timeout_ticks;
                     drain_in   = 1'b1;
                     if (start_zero) begin
                        active_in     = 1'b0;
                        res_push      = 1'b1;
                        res.last      = 1'b1;
                        res.end_cause = (cmd.timeout_ticks == 16'd0) ?
                                        urxf_pkg::CAUSE_TIMEOUT : urxf_pkg::CAUSE_LENGTH;
                     end else begin
                        active_in = 1'b1;
                     end
                  end
                  urxf_pkg::ACT_FLUSH: begin
                     rd_idx_in = wr_idx_ff;
                  end
                  default: ;
               endcase
            end
         end
         urxf_pkg::BE_EMIT: begin
            // Hand out the fetched byte; hold while the result queue is full
            if (res_space) begin
               res_push           = 1'b1;
               res.byte_valid     = 1'b1;
               res.byte_out       = rd_data_ff;
               res.received_count = count_inc;
               res.last           = done;
               res.end_cause      = urxf_pkg::CAUSE_LENGTH;
               rd_idx_in          = rd_next;
               count_in           = count_inc;
               idle_in            = 8'd0;
               if (done) begin
                  active_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= urxf_pkg::BE_IDLE;
         wr_idx_ff  <= '0;
         rd_idx_ff  <= '0;
         active_ff  <= 1'b0;
         drain_ff   <= 1'b0;
         count_ff   <= 16'd0;
         elapsed_ff <= 16'd0;
         idle_ff    <= 8'd0;
         limit_ff   <= 16'd0;
         timeout_ff <= 16'd0;
      end else begin
         state_ff   <= state_in;
         wr_idx_ff  <= wr_idx_in;
         rd_idx_ff  <= rd_idx_in;
         active_ff  <= active_in;
         drain_ff   <= drain_in;
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
         idle_ff    <= idle_in;
         limit_ff   <= limit_in;
         timeout_ff <= timeout_in;
      end
   end

   // Byte ring: one write port, registered read at the read index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ff] <= cmd.rx_data;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   a_push_has_space: assert property (@(posedge clock) disable iff (reset)
      res_push |-> res_space)
      else $error("result pushed into a full result queue");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (res_push && res.last) |=> !active_ff)
      else $error("session still open after its last result");

   a_fetch_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == urxf_pkg::BE_FETCH) |-> (rd_idx_ff != wr_idx_ff))
      else $error("fetch from an empty ring");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == urxf_pkg::BE_EMIT && !res_space) |=>
      (state_ff == urxf_pkg::BE_EMIT && $stable(rd_idx_ff)))
      else $error("stalled delivery did not hold");

endmodule

// ----- rtl/urxf_rspq.sv -----
// Result queue: decouples the back end from the response consumer.
`timescale 1ns / 1ps

module urxf_rspq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    res_push,
   input  urxf_pkg::result_type    res,
   output logic                    res_space,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output urxf_pkg::result_type    head
);

   urxf_pkg::result_type           queue_ff [urxf_pkg::QUEUE_DEPTH];
   logic [urxf_pkg::QPTR_W-1:0]    wp_ff, wp_in;
   logic [urxf_pkg::QPTR_W-1:0]    rp_ff, rp_in;
   logic [urxf_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                           do_push;
   logic                           do_pop;

   assign res_space = (cnt_ff != urxf_pkg::QCNT_W'(urxf_pkg::QUEUE_DEPTH));
   assign rsp_empty = (cnt_ff == '0);
   assign head      = queue_ff[rp_ff];
   assign do_push   = res_push && res_space;
   assign do_pop    = rsp_pop && !rsp_empty;

   // Advance pointers and occupancy
   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop  ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the result payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wp_ff] <= res;
      end
   end

endmodule

// ----- tb/sv/uart_rx_fifo_gap_framer_checker.sv -----
// Channel monitor that predicts the framer results and compares them with the block.
`timescale 1ns / 1ps

module uart_rx_fifo_gap_framer_checker
   import urxf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [1:0]  req_action,
   input  logic        req_rx_valid,
   input  logic [7:0]  req_rx_data,
   input  logic [15:0] req_max_length,
   input  logic [15:0] req_timeout_ticks,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_byte_valid,
   input  logic [7:0]  rsp_byte_out,
   input  logic [15:0] rsp_received_count,
   input  logic        rsp_last,
   input  logic [1:0]  rsp_end_cause,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_gap_ticks,
   output int          error_count,
   output int          pending_count
);

   localparam int RING = FIFO_DEPTH_DEF;

   // Shadow of the receive ring and the session counters
   logic [7:0]  ring_bytes [RING];
   int          wr_ptr;
   int          rd_ptr;
   logic        in_session;
   logic [15:0] delivered;
   logic [15:0] tick_total;
   logic [7:0]  idle_run;
   logic [15:0] len_limit;
   logic [15:0] tick_limit;
   logic [7:0]  gap_setting;

   result_type  expected_results[$];
   int          errors;

   // Build one result; the count is taken from the session as it stands
   function automatic result_type make_result(logic valid, logic [7:0] data, logic fin,
                                              cause_type cause);
      result_type r;
      r.byte_valid     = valid;
      r.byte_out       = data;
      r.received_count = delivered;
      r.last           = fin;
      r.end_cause      = fin ? cause : CAUSE_LENGTH;
      return r;
   endfunction

   // Hand out the oldest buffered byte and close the session at the length limit
   task automatic deliver_byte(output logic done);
      logic [7:0] data;
      data      = ring_bytes[rd_ptr];
      rd_ptr    = (rd_ptr + 1) % RING;
      delivered = delivered + 16'd1;
      idle_run  = 8'd0;
      done      = (delivered >= len_limit);
      expected_results.push_back(make_result(1'b1, data, done, CAUSE_LENGTH));
      if (done) begin
         in_session = 1'b0;
      end
   endtask

   // Advance the shadow state by one accepted request and queue what it yields
   task automatic predict_request(action_type act, logic vld, logic [7:0] data,
                                  logic [15:0] mlen, logic [15:0] tmo);
      int         nxt;
      int         n;
      logic       done;
      logic [7:0] gap;
      case (act)
         ACT_RX: begin
            if (vld) begin
               nxt = (wr_ptr + 1) % RING;
               // drop the byte when the ring is full
               if (nxt != rd_ptr) begin
                  ring_bytes[wr_ptr] = data;
                  wr_ptr = nxt;
               end
               if (in_session && rd_ptr != wr_ptr) begin
                  deliver_byte(done);
               end
            end
         end
         ACT_TICK: begin
            if (in_session) begin
               if (tick_total != ELAPSED_MAX) begin
                  tick_total = tick_total + 16'd1;
               end
               if (idle_run != IDLE_MAX) begin
                  idle_run = idle_run + 8'd1;
               end
               gap = (gap_setting == 8'd0) ? 8'd1 : gap_setting;
               // total timeout takes priority over the idle gap
               if (tick_total >= tick_limit) begin
                  in_session = 1'b0;
                  expected_results.push_back(make_result(1'b0, 8'd0, 1'b1, CAUSE_TIMEOUT));
               end else if (delivered != 16'd0 && idle_run >= gap) begin
                  in_session = 1'b0;
                  expected_results.push_back(make_result(1'b0, 8'd0, 1'b1, CAUSE_GAP));
               end
            end
         end
         ACT_START: begin
            delivered  = 16'd0;
            tick_total = 16'd0;
            idle_run   = 8'd0;
            len_limit  = mlen;
            tick_limit = tmo;
            if (tmo == 16'd0 || mlen == 16'd0) begin
               in_session = 1'b0;
               expected_results.push_back(make_result(1'b0, 8'd0, 1'b1,
                  (tmo == 16'd0) ? CAUSE_TIMEOUT : CAUSE_LENGTH));
            end else begin
               in_session = 1'b1;
               n = 0;
               done = 1'b0;
               // drain what is buffered until the limit closes the session
               while (rd_ptr != wr_ptr && n < RING && !done) begin
                  deliver_byte(done);
                  n++;
               end
            end
         end
         ACT_FLUSH: begin
            rd_ptr = wr_ptr;
         end
         default: ;
      endcase
   endtask

   // Compare one popped result with the oldest expectation
   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: result without request: valid %0b byte %02h count %0d last %0b cause %0d",
                     $time, rsp_byte_valid, rsp_byte_out, rsp_received_count, rsp_last,
                     rsp_end_cause);
         end
      end else begin
         want = expected_results.pop_front();
         if (rsp_byte_valid !== want.byte_valid || rsp_byte_out !== want.byte_out ||
             rsp_received_count !== want.received_count || rsp_last !== want.last ||
             rsp_end_cause !== want.end_cause) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: mismatch exp valid %0b byte %02h count %0d last %0b cause %0d",
                        $time, want.byte_valid, want.byte_out, want.received_count, want.last,
                        want.end_cause);
               $display("%0t:          got valid %0b byte %02h count %0d last %0b cause %0d",
                        $time, rsp_byte_valid, rsp_byte_out, rsp_received_count, rsp_last,
                        rsp_end_cause);
            end
         end
      end
   endtask

   // Sample all channels at the rising edge: results first, then register, then request
   always @(posedge clock) begin
      if (reset) begin
         wr_ptr      = 0;
         rd_ptr      = 0;
         in_session  = 1'b0;
         delivered   = 16'd0;
         tick_total  = 16'd0;
         idle_run    = 8'd0;
         len_limit   = 16'd0;
         tick_limit  = 16'd0;
         gap_setting = GAP_TICKS_RST;
         errors      = 0;
         expected_results.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_result();
         end
         if (csr_valid && csr_ready) begin
            gap_setting = csr_gap_ticks;
         end
         if (req_push && !req_full) begin
            predict_request(action_type'(req_action), req_rx_valid, req_rx_data,
                            req_max_length, req_timeout_ticks);
         end
      end
      error_count   <= errors;
      pending_count <= expected_results.size();
   end

endmodule

// ----- tb/sv/uart_rx_fifo_gap_framer_tb.sv -----
// Top of the framer testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module uart_rx_fifo_gap_framer_tb;
   import urxf_pkg::*;

   localparam int RUN_LIMIT = 5_000_000;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_push          = 1'b0;
   logic [1:0]  req_action        = ACT_RX;
   logic        req_rx_valid      = 1'b0;
   logic [7:0]  req_rx_data       = 8'd0;
   logic [15:0] req_max_length    = 16'd0;
   logic [15:0] req_timeout_ticks = 16'd0;
   logic        rsp_pop           = 1'b0;
   logic        csr_valid         = 1'b0;
   logic [7:0]  csr_gap_ticks     = GAP_TICKS_RST;

   wire         req_full;
   wire         rsp_empty;
   wire         rsp_byte_valid;
   wire  [7:0]  rsp_byte_out;
   wire  [15:0] rsp_received_count;
   wire         rsp_last;
   wire  [1:0]  rsp_end_cause;
   wire         csr_ready;

   int          fail_total;
   int          pending;
   int          sent       = 0;
   int          stall_left = 0;
   logic        calm       = 1'b0;

   uart_rx_fifo_gap_framer dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_action         (req_action),
      .req_rx_valid       (req_rx_valid),
      .req_rx_data        (req_rx_data),
      .req_max_length     (req_max_length),
      .req_timeout_ticks  (req_timeout_ticks),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_received_count (rsp_received_count),
      .rsp_last           (rsp_last),
      .rsp_end_cause      (rsp_end_cause),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_gap_ticks      (csr_gap_ticks)
   );

   uart_rx_fifo_gap_framer_checker framer_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_action         (req_action),
      .req_rx_valid       (req_rx_valid),
      .req_rx_data        (req_rx_data),
      .req_max_length     (req_max_length),
      .req_timeout_ticks  (req_timeout_ticks),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_received_count (rsp_received_count),
      .rsp_last           (rsp_last),
      .rsp_end_cause      (rsp_end_cause),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_gap_ticks      (csr_gap_ticks),
      .error_count        (fail_total),
      .pending_count      (pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Length of an idle run: mostly short, a few long
   function automatic int pick_run(int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) begin
         return 0;
      end else if (r < zero_pct + (100 - zero_pct) * 85 / 100) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Session limit or timeout: mostly small, sometimes zero or full range
   function automatic logic [15:0] pick_limit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 16'($urandom_range(1, 12));
      end else if (r < 88) begin
         return 16'($urandom_range(13, 40));
      end else if (r < 96) begin
         return 16'($urandom_range(0, 65535));
      end
      return 16'd0;
   endfunction

   // Offer one request and hold it until accepted, then maybe idle
   task automatic send_item(action_type act, logic vld, logic [7:0] data,
                            logic [15:0] mlen, logic [15:0] tmo);
      int pause;
      req_action        <= act;
      req_rx_valid      <= vld;
      req_rx_data       <= data;
      req_max_length    <= mlen;
      req_timeout_ticks <= tmo;
      req_push          <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      if (!(act == ACT_RX && !vld)) begin
         sent++;
      end
      pause = calm ? 0 : pick_run(50);
      if (pause > 0) begin
         req_push <= 1'b0;
         repeat (pause) @(negedge clock);
      end
   endtask

   // Drop push and hold until every expected result has arrived, then settle
   task automatic drain_wait(int settle);
      req_push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Write the idle gap register
   task automatic write_gap(logic [7:0] value);
      csr_gap_ticks <= value;
      csr_valid     <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: pop with random stalls, none in calm stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_pop <= 1'b0;
         stall_left = pick_run(0) - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Hard stop on a hung run
   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // Request stimulus and verdict
   initial begin
      logic [7:0] gap_plan [8];
      int         phase;
      int         target;
      int         r;
      int         k;
      logic       paused;

      gap_plan[0] = 8'd0;
      gap_plan[1] = 8'd1;
      gap_plan[2] = 8'd255;
      gap_plan[3] = 8'd3;
      gap_plan[4] = 8'd2;
      gap_plan[5] = 8'($urandom_range(1, 255));
      gap_plan[6] = 8'd128;
      gap_plan[7] = 8'd5;
      paused = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, gap at its reset value
      // zero length, then zero timeout: single closing result
      send_item(ACT_START, 1'b0, 8'h00, 16'd0, 16'd5);
      send_item(ACT_START, 1'b0, 8'h00, 16'd5, 16'd0);
      // tick and data-less rx outside a session are ignored
      send_item(ACT_TICK, 1'b0, 8'h00, 16'd0, 16'd0);
      send_item(ACT_RX, 1'b0, 8'hFF, 16'hFFFF, 16'hFFFF);
      // buffer the byte extremes, then drain them into an open session
      send_item(ACT_RX, 1'b1, 8'h00, 16'd0, 16'd0);
      send_item(ACT_RX, 1'b1, 8'hFF, 16'd0, 16'd0);
      send_item(ACT_START, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(ACT_RX, 1'b1, 8'hA5, 16'd0, 16'd0);
      // idle gap closes the session
      send_item(ACT_TICK, 1'b0, 8'h00, 16'd0, 16'd0);
      send_item(ACT_TICK, 1'b0, 8'h00, 16'd0, 16'd0);
      // length limit reached on a live byte
      send_item(ACT_START, 1'b0, 8'h00, 16'd2, 16'd3);
      send_item(ACT_RX, 1'b1, 8'h5A, 16'd0, 16'd0);
      send_item(ACT_RX, 1'b1, 8'h3C, 16'd0, 16'd0);
      // timeout and gap on the same tick: timeout wins
      send_item(ACT_START, 1'b0, 8'h00, 16'd10, 16'd2);
      send_item(ACT_RX, 1'b1, 8'h01, 16'd0, 16'd0);
      send_item(ACT_TICK, 1'b0, 8'h00, 16'd0, 16'd0);
      send_item(ACT_TICK, 1'b0, 8'h00, 16'd0, 16'd0);
      // flush drops the buffered byte, the session then times out empty
      send_item(ACT_RX, 1'b1, 8'h07, 16'd0, 16'd0);
      send_item(ACT_FLUSH, 1'b0, 8'h00, 16'd0, 16'd0);
      send_item(ACT_START, 1'b0, 8'h00, 16'd1, 16'd1);
      send_item(ACT_TICK, 1'b0, 8'h00, 16'd0, 16'd0);
      // restart abandons the open session
      send_item(ACT_START, 1'b0, 8'h00, 16'd3, 16'd9);
      send_item(ACT_START, 1'b0, 8'h00, 16'd4, 16'd1);
      send_item(ACT_TICK, 1'b0, 8'h00, 16'd0, 16'd0);

      // Random part, one gap setting per phase
      for (phase = 0; phase < 8; phase++) begin
         drain_wait(24);
         write_gap(gap_plan[phase]);
         calm <= (phase == 1 || phase == 5);
         target = sent + 40;
         while (sent < target) begin
            // hold off once until the block has delivered everything
            if (phase == 3 && !paused && sent >= target - 20) begin
               drain_wait(0);
               paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
               // session: buffer some bytes, start, then mixed traffic
               k = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 36) : $urandom_range(0, 5);
               repeat (k) begin
                  send_item(ACT_RX, 1'b1, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
               end
               send_item(ACT_START, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         pick_limit(), pick_limit());
               k = $urandom_range(2, 14);
               repeat (k) begin
                  r = $urandom_range(0, 99);
                  if (r < 50) begin
                     send_item(ACT_RX, ($urandom_range(0, 9) != 0), 8'($urandom_range(0, 255)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                  end else if (r < 94) begin
                     send_item(ACT_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                  end else begin
                     send_item(ACT_FLUSH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                  end
               end
               repeat ($urandom_range(0, 4)) begin
                  send_item(ACT_TICK, 1'b0, 8'h00, 16'd0, 16'd0);
               end
            end else if (r < 90) begin
               // noise: anything in any field
               repeat ($urandom_range(1, 4)) begin
                  send_item(action_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)));
               end
            end else begin
               // overflow: close any session, overfill the ring, drain it all
               send_item(ACT_START, 1'b0, 8'h00, 16'd0, 16'($urandom_range(0, 65535)));
               repeat ($urandom_range(32, 36)) begin
                  send_item(ACT_RX, 1'b1, 8'($urandom_range(0, 255)), 16'd0, 16'd0);
               end
               send_item(ACT_START, 1'b1, 8'h00, 16'hFFFF, 16'hFFFF);
            end
         end
      end

      drain_wait(40);
      if (fail_total == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/urxf_pkg.sv
rtl/urxf_front.sv
rtl/urxf_back.sv
rtl/urxf_rspq.sv
rtl/uart_rx_fifo_gap_framer.sv
tb/sv/uart_rx_fifo_gap_framer_checker.sv
tb/sv/uart_rx_fifo_gap_framer_tb.sv
